>>> sv/joystick_matrix_cursor_assert.svh
// ---------------------------------------------------------------------------
// Joystick matrix cursor assertion macros
// Concurrent assertion wrappers shared by the RTL modules. Synthesis sees
// empty bodies.
// ---------------------------------------------------------------------------
`ifndef JOYSTICK_MATRIX_CURSOR_ASSERT_SVH
`define JOYSTICK_MATRIX_CURSOR_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every rising clock edge while reset is released.
`define JMC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("joystick_matrix_cursor assertion failed");

// Checked on every rising clock edge, reset included.
`define JMC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("joystick_matrix_cursor assertion failed");

`else

`define JMC_ASSERT(lbl, clk, rstn, prop)
`define JMC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> sv/jmc_pkg.sv
// ---------------------------------------------------------------------------
// Joystick matrix cursor package
// Shared widths, reset values, register indexes, types and the LFSR step.
// ---------------------------------------------------------------------------
package jmc_pkg;

  localparam int ROW_LENGTH_DEF = 8;
  localparam int LED_COUNT_DEF  = 64;

  localparam int SAMPLE_W   = 10;
  localparam int CENTER_W   = 10;
  localparam int DZ_W       = 9;
  localparam int COOL_W     = 8;
  localparam int COLOR_W    = 8;
  localparam int IDX_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CENTER_W-1:0] CENTER_RST = 10'd512;
  localparam logic [DZ_W-1:0]     DZ_RST     = 9'd90;
  localparam logic [COOL_W-1:0]   COOL_RST   = 8'd10;
  localparam logic [COLOR_W-1:0]  BRIGHT_RST = 8'd80;

  localparam logic [COLOR_W-1:0] LFSR_TAPS = 8'hB8;
  localparam logic [COLOR_W-1:0] LFSR_SEED = 8'hA5;
  localparam logic [COLOR_W-1:0] RED_RST   = 8'hFF;
  localparam logic [COLOR_W-1:0] GREEN_RST = 8'h00;
  localparam logic [COLOR_W-1:0] BLUE_RST  = 8'h00;

  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_CENTER    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_POLLS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS     = 2'd3;

  typedef struct packed {
    logic [CENTER_W-1:0] axis_center;
    logic [DZ_W-1:0]     dead_zone;
    logic [COOL_W-1:0]   cooldown_polls;
    logic [COLOR_W-1:0]  brightness;
  } jmc_cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] x_sample;
    logic [SAMPLE_W-1:0] y_sample;
    logic                button_down;
  } jmc_poll_t;

  // One Galois step: shift right, fold the taps in when a one drops out.
  function automatic logic [COLOR_W-1:0] lfsr_step(input logic [COLOR_W-1:0] s);
    logic [COLOR_W-1:0] shifted;
    shifted = {1'b0, s[COLOR_W-1:1]};
    return s[0] ? (shifted ^ LFSR_TAPS) : shifted;
  endfunction

endpackage

>>> sv/jmc_move.sv
// ---------------------------------------------------------------------------
// Joystick matrix cursor movement
// Holds the cursor, its column and the cooldown; computes one poll's move.
// ---------------------------------------------------------------------------
module jmc_move
  import jmc_pkg::*;
#(
  parameter int ROW_LENGTH = ROW_LENGTH_DEF,
  parameter int LED_COUNT  = LED_COUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  jmc_cfg_t                       cfg_i,
  input  jmc_poll_t                      poll_i,
  output logic [$clog2(LED_COUNT)-1:0]   pos_next_o
);

`include "joystick_matrix_cursor_assert.svh"

  localparam int POS_W = $clog2(LED_COUNT);
  localparam int COL_W = $clog2(ROW_LENGTH);
  localparam int SUM_W = $clog2(LED_COUNT + ROW_LENGTH + 1);

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [COOL_W-1:0] cool_q, cool_d;

  logic [CENTER_W:0] th_hi;
  logic [CENTER_W:0] x_ext, y_ext, x_lo_sum, y_lo_sum, center_ext;
  logic              x_hi, x_lo, y_hi, y_lo;
  logic [POS_W-1:0]  pos_x;
  logic [COL_W-1:0]  col_x;
  logic [SUM_W-1:0]  pos_x_ext, pos_down, pos_plus1;

  // The low threshold is tested as x + dead_zone < center, so a negative
  // threshold never matches without any signed arithmetic.
  always_comb begin
    center_ext = {1'b0, cfg_i.axis_center};
    th_hi      = center_ext + (CENTER_W+1)'(cfg_i.dead_zone);
    x_ext      = {1'b0, poll_i.x_sample};
    y_ext      = {1'b0, poll_i.y_sample};
    x_lo_sum   = x_ext + (CENTER_W+1)'(cfg_i.dead_zone);
    y_lo_sum   = y_ext + (CENTER_W+1)'(cfg_i.dead_zone);
    x_hi       = x_ext > th_hi;
    x_lo       = x_lo_sum < center_ext;
    y_hi       = y_ext > th_hi;
    y_lo       = y_lo_sum < center_ext;
  end

  always_comb begin
    pos_x     = pos_q;
    col_x     = col_q;
    pos_plus1 = SUM_W'(pos_q) + SUM_W'(1);
    if (x_hi) begin
      if (col_q != '0) begin
        pos_x = pos_q - POS_W'(1);
        col_x = col_q - COL_W'(1);
      end
    end else if (x_lo) begin
      if ((col_q != COL_W'(ROW_LENGTH - 1)) && (pos_plus1 < SUM_W'(LED_COUNT))) begin
        pos_x = pos_q + POS_W'(1);
        col_x = col_q + COL_W'(1);
      end
    end

    pos_x_ext = SUM_W'(pos_x);
    pos_down  = pos_x_ext + SUM_W'(ROW_LENGTH);

    pos_d  = pos_q;
    col_d  = col_q;
    cool_d = cool_q;
    if (cool_q != '0) begin
      cool_d = cool_q - COOL_W'(1);
    end else begin
      pos_d = pos_x;
      col_d = col_x;
      if (x_hi || x_lo || y_hi || y_lo) begin
        cool_d = cfg_i.cooldown_polls;
      end
      if (y_hi) begin
        if (pos_down < SUM_W'(LED_COUNT)) begin
          pos_d = pos_down[POS_W-1:0];
        end
      end else if (y_lo) begin
        if (pos_x_ext >= SUM_W'(ROW_LENGTH)) begin
          pos_d = POS_W'(pos_x_ext - SUM_W'(ROW_LENGTH));
        end
      end
    end
  end

  assign pos_next_o = pos_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      col_q  <= '0;
      cool_q <= '0;
    end else if (step_i) begin
      pos_q  <= pos_d;
      col_q  <= col_d;
      cool_q <= cool_d;
    end
  end

  `JMC_ASSERT(a_pos_in_grid, clk_i, rst_ni, SUM_W'(pos_q) < SUM_W'(LED_COUNT))
  `JMC_ASSERT(a_col_in_row, clk_i, rst_ni, 32'(col_q) < ROW_LENGTH)
  `JMC_ASSERT(a_cooldown_holds_pos, clk_i, rst_ni, step_i && (cool_q != '0) |=> $stable(pos_q))

endmodule

>>> sv/jmc_color.sv
// ---------------------------------------------------------------------------
// Joystick matrix cursor color
// Button edge detect, LFSR color picks and brightness scaling by v*s/255.
// ---------------------------------------------------------------------------
module jmc_color
  import jmc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               button_i,
  input  logic [COLOR_W-1:0] brightness_i,
  output logic               changed_o,
  output logic [COLOR_W-1:0] raw_red_o,
  output logic [COLOR_W-1:0] raw_green_o,
  output logic [COLOR_W-1:0] raw_blue_o,
  output logic [COLOR_W-1:0] lit_red_o,
  output logic [COLOR_W-1:0] lit_green_o,
  output logic [COLOR_W-1:0] lit_blue_o
);

`include "joystick_matrix_cursor_assert.svh"

  logic               was_down_q;
  logic [COLOR_W-1:0] lfsr_q, lfsr_d;
  logic [COLOR_W-1:0] red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic               rise;

  // floor(p/255) for p up to 255*255: ((p+1) + ((p+1) >> 8)) >> 8.
  function automatic logic [COLOR_W-1:0] scale(input logic [COLOR_W-1:0] v,
                                               input logic [COLOR_W-1:0] s);
    logic [2*COLOR_W:0] p;
    logic [2*COLOR_W:0] q;
    p = (2*COLOR_W+1)'(v) * (2*COLOR_W+1)'(s) + (2*COLOR_W+1)'(1);
    q = p + (p >> COLOR_W);
    return q[2*COLOR_W-1:COLOR_W];
  endfunction

  always_comb begin
    rise    = button_i && !was_down_q;
    red_d   = red_q;
    green_d = green_q;
    blue_d  = blue_q;
    lfsr_d  = lfsr_q;
    if (rise) begin
      red_d   = lfsr_step(lfsr_q);
      green_d = lfsr_step(red_d);
      blue_d  = lfsr_step(green_d);
      lfsr_d  = blue_d;
    end
  end

  assign changed_o   = rise;
  assign raw_red_o   = red_d;
  assign raw_green_o = green_d;
  assign raw_blue_o  = blue_d;
  assign lit_red_o   = scale(red_d, brightness_i);
  assign lit_green_o = scale(green_d, brightness_i);
  assign lit_blue_o  = scale(blue_d, brightness_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_down_q <= 1'b0;
      lfsr_q     <= LFSR_SEED;
      red_q      <= RED_RST;
      green_q    <= GREEN_RST;
      blue_q     <= BLUE_RST;
    end else if (step_i) begin
      was_down_q <= button_i;
      lfsr_q     <= lfsr_d;
      red_q      <= red_d;
      green_q    <= green_d;
      blue_q     <= blue_d;
    end
  end

  `JMC_ASSERT(a_lfsr_only_on_press, clk_i, rst_ni, step_i && !rise |=> $stable(lfsr_q))
  `JMC_ASSERT(a_blue_tracks_lfsr, clk_i, rst_ni, step_i && rise |=> blue_q == lfsr_q)
  `JMC_ASSERT(a_change_needs_press, clk_i, rst_ni, changed_o |-> button_i)

endmodule

>>> sv/joystick_matrix_cursor.sv
// ---------------------------------------------------------------------------
// Joystick matrix cursor
// Moves a cursor over an LED grid from joystick polls and picks colors.
// ---------------------------------------------------------------------------
// One poll (x_sample, y_sample, button_down) enters on the input channel when
// in_valid_i is high and in_stall_o is low. Each poll yields exactly one
// result on the output channel: the cursor index, the brightness-scaled color,
// the raw color and a flag that tells whether this poll picked a new color.
// A poll is held in an input register; the movement, cooldown and color
// logic run on it, and when the poll advances the result is registered in
// the output register. One poll per cycle is sustained while out_stall_i
// is low; the single pass through the movement and scaling logic between
// those two registers sets that rate.
// When out_stall_i holds a result, the input register still takes one more
// poll, and in_stall_o rises only while both registers are full.
// The configuration registers are written through cfg_we_i, cfg_index_i and
// cfg_data_i, by the user only while no poll is in flight; nothing enforces it.
// Reset clears both channels, centers the axes at 512 with a dead zone of 90,
// a reload of 10 polls and brightness 80, puts the cursor at LED 0 and the
// color at full red.
// ---------------------------------------------------------------------------
module joystick_matrix_cursor
  import jmc_pkg::*;
#(
  parameter int ROW_LENGTH = ROW_LENGTH_DEF,
  parameter int LED_COUNT  = LED_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [SAMPLE_W-1:0]   x_sample_i,
  input  logic [SAMPLE_W-1:0]   y_sample_i,
  input  logic                  button_down_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [IDX_W-1:0]      cursor_index_o,
  output logic [COLOR_W-1:0]    lit_green_o,
  output logic [COLOR_W-1:0]    lit_red_o,
  output logic [COLOR_W-1:0]    lit_blue_o,
  output logic                  color_changed_o,
  output logic [COLOR_W-1:0]    raw_red_o,
  output logic [COLOR_W-1:0]    raw_green_o,
  output logic [COLOR_W-1:0]    raw_blue_o
);

`include "joystick_matrix_cursor_assert.svh"

  localparam int POS_W = $clog2(LED_COUNT);

  jmc_cfg_t  cfg_q, cfg_d;
  jmc_poll_t poll_q;
  logic      in_valid_q, in_valid_d;
  logic      out_valid_q, out_valid_d;
  logic      in_accept, advance;

  logic [POS_W-1:0]       pos_next;
  logic [IDX_W+POS_W-1:0] pos_wide;
  logic                   changed;
  logic [COLOR_W-1:0]     raw_r, raw_g, raw_b, lit_r, lit_g, lit_b;

  logic [IDX_W-1:0]   idx_q;
  logic               changed_q;
  logic [COLOR_W-1:0] raw_r_q, raw_g_q, raw_b_q, lit_r_q, lit_g_q, lit_b_q;

  // Configuration writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_AXIS_CENTER:    cfg_d.axis_center    = cfg_data_i[CENTER_W-1:0];
        CFG_DEAD_ZONE:      cfg_d.dead_zone      = cfg_data_i[DZ_W-1:0];
        CFG_COOLDOWN_POLLS: cfg_d.cooldown_polls = cfg_data_i[COOL_W-1:0];
        CFG_BRIGHTNESS:     cfg_d.brightness     = cfg_data_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.axis_center    <= CENTER_RST;
      cfg_q.dead_zone      <= DZ_RST;
      cfg_q.cooldown_polls <= COOL_RST;
      cfg_q.brightness     <= BRIGHT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Handshake: the poll register moves on whenever the result register is
  // empty or being emptied in this cycle.
  always_comb begin
    advance     = in_valid_q && (!out_valid_q || !out_stall_i);
    in_stall_o  = in_valid_q && !advance;
    in_accept   = in_valid_i && !in_stall_o;
    in_valid_d  = in_accept || (in_valid_q && !advance);
    out_valid_d = advance || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      poll_q.x_sample    <= x_sample_i;
      poll_q.y_sample    <= y_sample_i;
      poll_q.button_down <= button_down_i;
    end
  end

  jmc_move #(
    .ROW_LENGTH (ROW_LENGTH),
    .LED_COUNT  (LED_COUNT)
  ) u_move (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .cfg_i      (cfg_q),
    .poll_i     (poll_q),
    .pos_next_o (pos_next)
  );

  jmc_color u_color (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .button_i     (poll_q.button_down),
    .brightness_i (cfg_q.brightness),
    .changed_o    (changed),
    .raw_red_o    (raw_r),
    .raw_green_o  (raw_g),
    .raw_blue_o   (raw_b),
    .lit_red_o    (lit_r),
    .lit_green_o  (lit_g),
    .lit_blue_o   (lit_b)
  );

  // The index port carries the low bits of the position, zero-filled when
  // the grid is small.
  assign pos_wide = {{IDX_W{1'b0}}, pos_next};

  always_ff @(posedge clk_i) begin
    if (advance) begin
      idx_q     <= pos_wide[IDX_W-1:0];
      changed_q <= changed;
      raw_r_q   <= raw_r;
      raw_g_q   <= raw_g;
      raw_b_q   <= raw_b;
      lit_r_q   <= lit_r;
      lit_g_q   <= lit_g;
      lit_b_q   <= lit_b;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cursor_index_o  = idx_q;
  assign color_changed_o = changed_q;
  assign raw_red_o       = raw_r_q;
  assign raw_green_o     = raw_g_q;
  assign raw_blue_o      = raw_b_q;
  assign lit_red_o       = lit_r_q;
  assign lit_green_o     = lit_g_q;
  assign lit_blue_o      = lit_b_q;

  `JMC_ASSERT(a_stall_only_when_full, clk_i, rst_ni, in_stall_o |-> (out_valid_q && out_stall_i))
  `JMC_ASSERT(a_advance_fills_output, clk_i, rst_ni, advance |=> out_valid_q)
  `JMC_ASSERT(a_accept_fills_input, clk_i, rst_ni, in_accept |=> in_valid_q)

endmodule
